@@ rtl/ahfr_pkg.sv @@
// Shared types and constants of the ASCII-hex frame receiver.
package ahfr_pkg;

   localparam int NODES    = 4;
   localparam int NODE_W   = $clog2(NODES);
   localparam int MAX_DATA = 32;
   localparam int DATA_AW  = $clog2(MAX_DATA);
   localparam int MEM_AW   = NODE_W + DATA_AW;
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = $clog2(QDEPTH);

   localparam logic [2:0] KIND_CHAR    = 3'd0;
   localparam logic [2:0] KIND_TIMEOUT = 3'd1;
   localparam logic [2:0] KIND_START   = 3'd2;
   localparam logic [2:0] KIND_READ    = 3'd3;
   localparam logic [2:0] KIND_RELEASE = 3'd4;

   localparam logic [3:0] ST_USER_OK   = 4'd0;
   localparam logic [3:0] ST_POLL_OK   = 4'd1;
   localparam logic [3:0] ST_TIMEOUT   = 4'd2;
   localparam logic [3:0] ST_FRAMING   = 4'd3;
   localparam logic [3:0] ST_CANCELLED = 4'd4;
   localparam logic [3:0] ST_ADDRESS   = 4'd5;
   localparam logic [3:0] ST_TYPE      = 4'd6;
   localparam logic [3:0] ST_FULL      = 4'd7;
   localparam logic [3:0] ST_CHECKSUM  = 4'd8;
   localparam logic [3:0] ST_READ      = 4'd9;
   localparam logic [3:0] ST_TOO_LONG  = 4'd10;

   localparam logic [1:0] CSR_NODE_ROLE = 2'd0;
   localparam logic [1:0] CSR_OWN_ADDR  = 2'd1;
   localparam logic [1:0] CSR_USER_TYPE = 2'd2;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_A_OFS = 8'h37;

   typedef struct packed {
      logic [2:0]        kind;
      logic [7:0]        nib;
      logic              colon;
      logic              lf;
      logic [NODE_W-1:0] node;
      logic [DATA_AW-1:0] idx;
   } item_type;

   typedef struct packed {
      logic       node_role;
      logic [1:0] own_address;
      logic       user_type_code;
   } cfg_type;

   typedef struct packed {
      logic [7:0] hw_src;
      logic [7:0] msg_type;
      logic [7:0] src;
      logic [7:0] dest;
      logic [7:0] lng;
   } meta_type;

endpackage

@@ rtl/ahfr_front.sv @@
// Front end: accepts input words and classifies them for the queue.
module ahfr_front (
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,
   input  logic [2:0]           req_tuser,
   input  logic                 q_full,
   output logic                 q_push,
   output ahfr_pkg::item_type   q_item
);

   logic [7:0] ch;
   logic       known;

   assign ch         = req_tdata[7:0];
   assign req_tready = !q_full;
   assign known      = (req_tuser == ahfr_pkg::KIND_CHAR) || (req_tuser == ahfr_pkg::KIND_TIMEOUT)
                    || (req_tuser == ahfr_pkg::KIND_START) || (req_tuser == ahfr_pkg::KIND_READ)
                    || (req_tuser == ahfr_pkg::KIND_RELEASE);
   assign q_push     = req_tvalid && !q_full && known;

   always_comb begin
      q_item.kind  = req_tuser;
      q_item.nib   = (ch > ahfr_pkg::CH_NINE) ? ch - ahfr_pkg::CH_A_OFS : ch - ahfr_pkg::CH_ZERO;
      q_item.colon = (ch == ahfr_pkg::CH_COLON);
      q_item.lf    = (ch == ahfr_pkg::CH_LF);
      q_item.node  = req_tdata[8 +: ahfr_pkg::NODE_W];
      q_item.idx   = req_tdata[10 +: ahfr_pkg::DATA_AW];
   end

endmodule

@@ rtl/ahfr_queue.sv @@
// Short queue of classified items between the front and back ends.
module ahfr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ahfr_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output ahfr_pkg::item_type head
);

   ahfr_pkg::item_type            slot_ff [ahfr_pkg::QDEPTH];
   logic [ahfr_pkg::QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [ahfr_pkg::QPTR_W:0]     cnt_ff, cnt_in;

   assign full  = (cnt_ff == (ahfr_pkg::QPTR_W+1)'(ahfr_pkg::QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (ahfr_pkg::QPTR_W+1)'(push) - (ahfr_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/ahfr_back.sv @@
// Back end: frame parser, node stores and result register.
module ahfr_back (
   input  logic               clock,
   input  logic               reset,
   input  ahfr_pkg::cfg_type  cfg,
   input  logic               q_empty,
   input  ahfr_pkg::item_type it,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [47:0]        rsp_tdata,
   output logic [3:0]         rsp_tuser
);

   localparam logic [2:0] PH_IDLE        = 3'd0;
   localparam logic [2:0] PH_MFIRST      = 3'd1;
   localparam logic [2:0] PH_DRAIN_FRAME = 3'd2;
   localparam logic [2:0] PH_DRAIN_ADDR  = 3'd3;
   localparam logic [2:0] PH_HUNT        = 3'd4;
   localparam logic [2:0] PH_HWADDR      = 3'd5;
   localparam logic [2:0] PH_BODY        = 3'd6;

   localparam int NW = ahfr_pkg::NODE_W;

   logic [2:0]        phase_ff, phase_in;
   logic              hnv_ff, hnv_in;
   logic [3:0]        hn_ff, hn_in;
   logic [7:0]        sum_ff, sum_in;
   logic [8:0]        fc_ff, fc_in;
   logic [7:0]        hdr_ff [5];
   logic [7:0]        hdr_in [5];
   logic [NW-1:0]     polled_ff, polled_in;
   logic [ahfr_pkg::NODES-1:0] full_ff, full_in;
   ahfr_pkg::meta_type meta_ff [ahfr_pkg::NODES];
   ahfr_pkg::meta_type meta_in [ahfr_pkg::NODES];
   logic              master_ff, master_in;
   logic [3:0]        err_ff, err_in;
   logic              sumok_ff, sumok_in;

   logic              rv_ff, rv_in;
   logic [3:0]        rst_ff, rst_in;
   logic [39:0]       rhdr_ff, rhdr_in;
   logic              rdsel_ff, rdsel_in;
   logic [7:0]        mq_ff;

   logic [7:0]        mem [ahfr_pkg::NODES * ahfr_pkg::MAX_DATA];
   logic              we;
   logic [ahfr_pkg::MEM_AW-1:0] waddr, raddr;

   logic [7:0]        byte_v;
   logic [NW-1:0]     tgt;
   logic              user;
   logic [8:0]        end_data, need;
   logic              own_ok;

   assign q_pop      = !q_empty && (!rv_ff || rsp_tready);
   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = rst_ff;
   assign rsp_tdata  = {(rdsel_ff ? mq_ff : 8'd0), rhdr_ff};
   assign raddr      = {it.node, it.idx};

   always_comb begin
      byte_v   = {hn_ff, 4'd0} + it.nib;
      tgt      = master_ff ? hdr_ff[3][NW-1:0] : cfg.own_address;
      user     = (hdr_ff[1] == {7'd0, cfg.user_type_code});
      end_data = {1'b0, hdr_ff[4]} + 9'd5;
      own_ok   = ({30'd0, cfg.own_address} < ahfr_pkg::NODES);
      if (user) begin
         need = (fc_ff >= 9'd5) ? end_data + 9'd1 : 9'd6;
      end else begin
         need = 9'd3;
      end

      phase_in  = phase_ff;
      hnv_in    = hnv_ff;
      hn_in     = hn_ff;
      sum_in    = sum_ff;
      fc_in     = fc_ff;
      hdr_in    = hdr_ff;
      polled_in = polled_ff;
      full_in   = full_ff;
      meta_in   = meta_ff;
      master_in = master_ff;
      err_in    = err_ff;
      sumok_in  = sumok_ff;
      rv_in     = rv_ff && !rsp_tready;
      rst_in    = rst_ff;
      rhdr_in   = rhdr_ff;
      rdsel_in  = rdsel_ff;
      we        = 1'b0;
      waddr     = {tgt, fc_ff[ahfr_pkg::DATA_AW-1:0] - ahfr_pkg::DATA_AW'(5)};

      if (q_pop) begin
         unique case (it.kind)
            ahfr_pkg::KIND_START: begin
               polled_in = it.node;
               master_in = cfg.node_role;
               for (int k = 0; k < 5; k++) hdr_in[k] = 8'd0;
               hnv_in    = 1'b0;
               sum_in    = 8'd0;
               fc_in     = 9'd0;
               err_in    = 4'd0;
               sumok_in  = 1'b0;
               phase_in  = cfg.node_role ? PH_MFIRST : PH_HUNT;
            end
            ahfr_pkg::KIND_READ: begin
               rv_in    = 1'b1;
               rst_in   = ahfr_pkg::ST_READ;
               rhdr_in  = {meta_ff[it.node].lng, meta_ff[it.node].dest, meta_ff[it.node].src,
                           meta_ff[it.node].msg_type, meta_ff[it.node].hw_src};
               rdsel_in = 1'b1;
            end
            ahfr_pkg::KIND_RELEASE: begin
               full_in[it.node] = 1'b0;
            end
            ahfr_pkg::KIND_TIMEOUT: begin
               rhdr_in  = {hdr_ff[4], hdr_ff[3], hdr_ff[2], hdr_ff[1], hdr_ff[0]};
               rdsel_in = 1'b0;
               unique case (phase_ff)
                  PH_MFIRST, PH_HUNT: begin
                     rv_in = 1'b1; rst_in = ahfr_pkg::ST_TIMEOUT; phase_in = PH_IDLE;
                  end
                  PH_HWADDR, PH_BODY: begin
                     rv_in = 1'b1; rst_in = ahfr_pkg::ST_CANCELLED; phase_in = PH_IDLE;
                  end
                  PH_DRAIN_FRAME: begin
                     rv_in = 1'b1; rst_in = ahfr_pkg::ST_FRAMING; phase_in = PH_IDLE;
                  end
                  PH_DRAIN_ADDR: begin
                     rv_in = 1'b1; rst_in = ahfr_pkg::ST_ADDRESS; phase_in = PH_IDLE;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
               unique case (phase_ff)
                  PH_MFIRST: begin
                     full_in[polled_ff] = 1'b0;
                     phase_in = it.colon ? PH_HWADDR : PH_DRAIN_FRAME;
                     hnv_in   = 1'b0;
                  end
                  PH_HUNT: begin
                     if (it.colon) begin
                        phase_in = PH_HWADDR;
                        hnv_in   = 1'b0;
                     end
                  end
                  PH_HWADDR: begin
                     if (hnv_ff) begin
                        hnv_in = 1'b0;
                        if (byte_v == {6'd0, cfg.own_address}) begin
                           phase_in = PH_BODY;
                           sum_in   = byte_v;
                           fc_in    = 9'd0;
                           err_in   = 4'd0;
                           sumok_in = 1'b0;
                        end else begin
                           phase_in = master_ff ? PH_DRAIN_ADDR : PH_HUNT;
                        end
                     end else begin
                        hnv_in = 1'b1;
                        hn_in  = it.nib[3:0];
                     end
                  end
                  PH_BODY: begin
                     if (it.lf) begin
                        rv_in    = 1'b1;
                        rdsel_in = 1'b0;
                        rhdr_in  = {hdr_ff[4], hdr_ff[3], hdr_ff[2], hdr_ff[1], hdr_ff[0]};
                        phase_in = PH_IDLE;
                        if (err_ff != 4'd0) begin
                           rst_in = err_ff;
                        end else if (fc_ff < 9'd2 || fc_ff < need) begin
                           rst_in = ahfr_pkg::ST_FRAMING;
                        end else if (user) begin
                           if (!sumok_ff) begin
                              rst_in = ahfr_pkg::ST_CHECKSUM;
                           end else begin
                              full_in[tgt] = 1'b1;
                              rst_in       = ahfr_pkg::ST_USER_OK;
                           end
                        end else begin
                           if (own_ok) meta_in[cfg.own_address].hw_src = hdr_ff[0];
                           rst_in = sumok_ff ? ahfr_pkg::ST_POLL_OK : ahfr_pkg::ST_CHECKSUM;
                        end
                     end else if (!hnv_ff) begin
                        hnv_in = 1'b1;
                        hn_in  = it.nib[3:0];
                     end else begin
                        hnv_in = 1'b0;
                        if (fc_ff != 9'h1FF) fc_in = fc_ff + 9'd1;
                        if (fc_ff < 9'd2) begin
                           hdr_in[fc_ff[2:0]] = byte_v;
                           sum_in = sum_ff + byte_v;
                           if (fc_ff == 9'd1 && byte_v > 8'd1 && err_ff == 4'd0)
                              err_in = ahfr_pkg::ST_TYPE;
                        end else if (user) begin
                           if (fc_ff < 9'd5) begin
                              hdr_in[fc_ff[2:0]] = byte_v;
                              sum_in = sum_ff + byte_v;
                              if (fc_ff == 9'd3 && err_ff == 4'd0 && master_ff) begin
                                 if ({24'd0, byte_v} >= ahfr_pkg::NODES)
                                    err_in = ahfr_pkg::ST_ADDRESS;
                                 else if (full_ff[byte_v[NW-1:0]])
                                    err_in = ahfr_pkg::ST_FULL;
                              end
                              if (fc_ff == 9'd4 && err_ff == 4'd0) begin
                                 if ({24'd0, byte_v} > ahfr_pkg::MAX_DATA) begin
                                    err_in = ahfr_pkg::ST_TOO_LONG;
                                 end else if (!master_ff && !own_ok) begin
                                    err_in = ahfr_pkg::ST_ADDRESS;
                                 end else begin
                                    if (master_ff) begin
                                       meta_in[tgt].hw_src   = {6'd0, cfg.own_address};
                                       meta_in[tgt].msg_type = hdr_ff[1];
                                       meta_in[tgt].dest     = hdr_ff[3];
                                    end
                                    meta_in[tgt].src = hdr_ff[2];
                                    meta_in[tgt].lng = byte_v;
                                 end
                              end
                           end else if (fc_ff < end_data) begin
                              sum_in = sum_ff + byte_v;
                              we     = (err_ff == 4'd0);
                           end else if (fc_ff == end_data) begin
                              sumok_in = (byte_v == sum_ff);
                           end
                        end else if (fc_ff == 9'd2) begin
                           sumok_in = (byte_v == sum_ff);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         hnv_ff    <= 1'b0;
         hn_ff     <= 4'd0;
         sum_ff    <= 8'd0;
         fc_ff     <= 9'd0;
         for (int k = 0; k < 5; k++) hdr_ff[k] <= 8'd0;
         polled_ff <= '0;
         full_ff   <= '0;
         for (int k = 0; k < ahfr_pkg::NODES; k++) meta_ff[k] <= '0;
         master_ff <= 1'b0;
         err_ff    <= 4'd0;
         sumok_ff  <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         hnv_ff    <= hnv_in;
         hn_ff     <= hn_in;
         sum_ff    <= sum_in;
         fc_ff     <= fc_in;
         hdr_ff    <= hdr_in;
         polled_ff <= polled_in;
         full_ff   <= full_in;
         meta_ff   <= meta_in;
         master_ff <= master_in;
         err_ff    <= err_in;
         sumok_ff  <= sumok_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      rst_ff   <= rst_in;
      rhdr_ff  <= rhdr_in;
      rdsel_ff <= rdsel_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= byte_v;
      end
      if (q_pop && it.kind == ahfr_pkg::KIND_READ) begin
         mq_ff <= mem[raddr];
      end
   end

endmodule

@@ rtl/ascii_hex_frame_receiver_core.sv @@
// Top level of the ASCII-hex frame receiver.
// The block takes one word per clock while its queue has room and returns at most one result
// word per input word, in order. A word passes the classifying front end into a four-entry
// queue and is carried out by the parser once it is at the queue head and the result register
// is free; with no back-pressure the sustained rate is one word per cycle, and a result is offered
// in the cycle after its word is carried out; the parser stalls only while a result waits to be taken.
// Read results take the stored byte from the data memory through its registered read port.
module ascii_hex_frame_receiver_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // char_code[7:0], node[9:8], byte_index[14:10], zeros
   input  logic [2:0]  req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // hw_source, msg_type, src_node, dest_node, length, data_byte
   output logic [3:0]  rsp_tuser,  // status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_data
);

   ahfr_pkg::cfg_type  cfg_ff;
   ahfr_pkg::item_type push_item, head;
   logic               q_full, q_push, q_pop, q_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_role      <= 1'b0;
         cfg_ff.own_address    <= 2'd0;
         cfg_ff.user_type_code <= 1'b1;
      end else if (csr_valid) begin
         if (csr_index == ahfr_pkg::CSR_NODE_ROLE) cfg_ff.node_role <= csr_data[0];
         if (csr_index == ahfr_pkg::CSR_OWN_ADDR) cfg_ff.own_address <= csr_data;
         if (csr_index == ahfr_pkg::CSR_USER_TYPE) cfg_ff.user_type_code <= csr_data[0];
      end
   end

   ahfr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   ahfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (head)
   );

   ahfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .it         (head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid after reset.");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("Queue popped while empty.");
   a_push_accepted: assert property (@(posedge clock) disable iff (reset)
      q_push |-> req_tvalid && req_tready)
      else $error("Queue pushed without an accepted word.");
   a_frame_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ahfr_pkg::ST_READ |-> rsp_tdata[47:40] == 8'd0)
      else $error("Frame result carries a data byte.");
`endif

endmodule

@@ tb/ascii_hex_frame_receiver_core_tb.sv @@
// Self-checking testbench of the ASCII-hex frame receiver with an in-bench behavioral predictor.
`timescale 1ns / 1ps

module ascii_hex_frame_receiver_core_tb;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 24;

   localparam logic [2:0] P_IDLE        = 3'd0;
   localparam logic [2:0] P_MFIRST      = 3'd1;
   localparam logic [2:0] P_DRAIN_FRAME = 3'd2;
   localparam logic [2:0] P_DRAIN_ADDR  = 3'd3;
   localparam logic [2:0] P_HUNT        = 3'd4;
   localparam logic [2:0] P_HWADDR      = 3'd5;
   localparam logic [2:0] P_BODY        = 3'd6;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] ch;
      logic [1:0] node;
      logic [4:0] idx;
   } event_word_type;

   typedef struct packed {
      logic [3:0] st;
      logic [7:0] hw, ty, sr, ds, ln, db;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [1:0]  csr_data = '0;

   ascii_hex_frame_receiver_core dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Predictor state.
   logic               cfg_role, cfg_utype;
   logic [1:0]         cfg_own;
   logic [2:0]         ph;
   logic [4:0]         hnib;
   logic [7:0]         rsum;
   int                 fcnt;
   logic [7:0]         hdr [5];
   logic [1:0]         polled;
   logic               full_flag [ahfr_pkg::NODES];
   ahfr_pkg::meta_type meta [ahfr_pkg::NODES];
   logic [7:0]         store [ahfr_pkg::NODES][ahfr_pkg::MAX_DATA];
   logic               written [ahfr_pkg::NODES][ahfr_pkg::MAX_DATA];
   logic               is_master_l, sum_ok;
   logic [7:0]         master_addr;
   logic [3:0]         err;

   event_word_type   pending_words [$];
   frame_result_type expected_results [$];

   int send_idle_pct = 0, recv_idle_pct = 0;
   int mismatches = 0, checked = 0, accepted = 0, quiet_cycles = 0, frames = 0;
   int seg, n_items;

   function automatic logic [7:0] nib_of(logic [7:0] c);
      return (c > ahfr_pkg::CH_NINE) ? c - ahfr_pkg::CH_A_OFS : c - ahfr_pkg::CH_ZERO;
   endfunction

   function automatic bit pair_in(logic [7:0] c, output logic [7:0] b);
      logic [7:0] n;
      n = nib_of(c);
      b = '0;
      if (hnib[4]) begin
         b = {hnib[3:0], 4'h0} + n;
         hnib = '0;
         return 1'b1;
      end
      hnib = {1'b1, n[3:0]};
      return 1'b0;
   endfunction

   function automatic logic [1:0] target_node();
      return is_master_l ? hdr[3][1:0] : cfg_own;
   endfunction

   function automatic void body_byte(logic [7:0] b);
      logic [1:0] t;
      if (fcnt < 2) begin
         hdr[fcnt] = b;
         rsum += b;
         if (fcnt == 1 && b > 1 && err == 0) err = ahfr_pkg::ST_TYPE;
      end else if (hdr[1] == {7'd0, cfg_utype}) begin
         if (fcnt < 5) begin
            hdr[fcnt] = b;
            rsum += b;
            if (fcnt == 3 && err == 0 && is_master_l) begin
               if (b >= ahfr_pkg::NODES) err = ahfr_pkg::ST_ADDRESS;
               else if (full_flag[b[1:0]]) err = ahfr_pkg::ST_FULL;
            end
            if (fcnt == 4 && err == 0) begin
               if (b > ahfr_pkg::MAX_DATA) err = ahfr_pkg::ST_TOO_LONG;
               else begin
                  t = target_node();
                  if (is_master_l) begin
                     meta[t].hw_src   = {6'd0, cfg_own};
                     meta[t].msg_type = hdr[1];
                     meta[t].dest     = hdr[3];
                  end
                  meta[t].src = hdr[2];
                  meta[t].lng = b;
               end
            end
         end else if (fcnt < 5 + hdr[4]) begin
            rsum += b;
            if (err == 0) begin
               t = target_node();
               store[t][fcnt-5]   = b;
               written[t][fcnt-5] = 1'b1;
            end
         end else if (fcnt == 5 + hdr[4]) begin
            sum_ok = (b == rsum);
         end
      end else if (fcnt == 2) begin
         sum_ok = (b == rsum);
      end
      fcnt++;
   endfunction

   function automatic frame_result_type emit(logic [3:0] st);
      frame_result_type r;
      r = {st, hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], 8'd0};
      ph = P_IDLE;
      return r;
   endfunction

   function automatic frame_result_type frame_end();
      int  need;
      logic user;
      if (!is_master_l && fcnt >= 1) master_addr = hdr[0];
      if (err != 0) return emit(err);
      if (fcnt < 2) return emit(ahfr_pkg::ST_FRAMING);
      user = (hdr[1] == {7'd0, cfg_utype});
      need = user ? ((fcnt >= 5) ? 6 + hdr[4] : 6) : 3;
      if (fcnt < need) return emit(ahfr_pkg::ST_FRAMING);
      if (user) begin
         if (!sum_ok) return emit(ahfr_pkg::ST_CHECKSUM);
         full_flag[target_node()] = 1'b1;
         return emit(ahfr_pkg::ST_USER_OK);
      end
      meta[cfg_own].hw_src = hdr[0];
      return emit(sum_ok ? ahfr_pkg::ST_POLL_OK : ahfr_pkg::ST_CHECKSUM);
   endfunction

   function automatic bit predict_event(event_word_type w, output frame_result_type r);
      logic [7:0] b;
      r = '0;
      case (w.kind)
         ahfr_pkg::KIND_START: begin
            polled = w.node;
            is_master_l = cfg_role;
            foreach (hdr[k]) hdr[k] = '0;
            hnib = '0; rsum = '0; fcnt = 0; err = '0; sum_ok = 1'b0;
            ph = cfg_role ? P_MFIRST : P_HUNT;
            return 1'b0;
         end
         ahfr_pkg::KIND_READ: begin
            r = {ahfr_pkg::ST_READ, meta[w.node], store[w.node][w.idx]};
            return 1'b1;
         end
         ahfr_pkg::KIND_RELEASE: begin
            full_flag[w.node] = 1'b0;
            return 1'b0;
         end
         ahfr_pkg::KIND_TIMEOUT: begin
            case (ph)
               P_MFIRST, P_HUNT:  r = emit(ahfr_pkg::ST_TIMEOUT);
               P_HWADDR, P_BODY:  r = emit(ahfr_pkg::ST_CANCELLED);
               P_DRAIN_FRAME:     r = emit(ahfr_pkg::ST_FRAMING);
               P_DRAIN_ADDR:      r = emit(ahfr_pkg::ST_ADDRESS);
               default:           return 1'b0;
            endcase
            return 1'b1;
         end
         ahfr_pkg::KIND_CHAR: begin
            case (ph)
               P_MFIRST: begin
                  full_flag[polled] = 1'b0;
                  ph = (w.ch == ahfr_pkg::CH_COLON) ? P_HWADDR : P_DRAIN_FRAME;
                  hnib = '0;
               end
               P_HUNT: begin
                  if (w.ch == ahfr_pkg::CH_COLON) begin
                     ph = P_HWADDR;
                     hnib = '0;
                  end
               end
               P_HWADDR: begin
                  if (pair_in(w.ch, b)) begin
                     if (b == {6'd0, cfg_own}) begin
                        ph = P_BODY; rsum = b; fcnt = 0; err = '0; sum_ok = 1'b0;
                     end else begin
                        ph = is_master_l ? P_DRAIN_ADDR : P_HUNT;
                     end
                  end
               end
               P_BODY: begin
                  if (w.ch == ahfr_pkg::CH_LF) begin
                     r = frame_end();
                     return 1'b1;
                  end
                  if (pair_in(w.ch, b)) body_byte(b);
               end
               default: ;
            endcase
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic push_word(logic [2:0] kind, logic [7:0] ch, logic [1:0] node, logic [4:0] idx);
      event_word_type   w;
      frame_result_type r;
      w = {kind, ch, node, idx};
      if (predict_event(w, r)) expected_results.push_back(r);
      pending_words.push_back(w);
      if (kind <= ahfr_pkg::KIND_RELEASE) n_items++;
   endtask

   task automatic push_char(logic [7:0] ch);
      push_word(ahfr_pkg::KIND_CHAR, ch, 2'($urandom), 5'($urandom));
   endtask

   task automatic push_hex(logic [7:0] b);
      logic [3:0] n;
      for (int k = 1; k >= 0; k--) begin
         n = b[k*4 +: 4];
         if ($urandom_range(49) == 0) push_char(8'($urandom));
         else push_char((n < 10) ? ahfr_pkg::CH_ZERO + n : ahfr_pkg::CH_A_OFS + n);
      end
   endtask

   task automatic push_read();
      int cand [$];
      logic [1:0] nd;
      nd = 2'($urandom);
      for (int i = 0; i < ahfr_pkg::MAX_DATA; i++) if (written[nd][i]) cand.push_back(i);
      if (cand.size() == 0) begin
         push_word(ahfr_pkg::KIND_RELEASE, 8'($urandom), nd, 5'($urandom));
      end else begin
         push_word(ahfr_pkg::KIND_READ, 8'($urandom), nd,
                   5'(cand[$urandom_range(cand.size() - 1)]));
      end
   endtask

   // cut < 0 sends the whole frame; otherwise only the first cut bytes go out.
   task automatic push_frame(logic [7:0] hwd, logic [7:0] typ, logic [7:0] dst, int len,
                             bit bad_sum, int cut, bit end_timeout, bit bad_first);
      logic [7:0] bytes [$];
      logic [7:0] sum;
      int nd;
      push_word(ahfr_pkg::KIND_START, 8'($urandom), 2'($urandom), 5'($urandom));
      if (!cfg_role) repeat ($urandom_range(3)) push_char(8'($urandom_range(0, 8'h39)));
      push_char(bad_first ? 8'h41 : ahfr_pkg::CH_COLON);
      bytes = {hwd, 8'($urandom), typ};
      if (typ == {7'd0, cfg_utype}) begin
         bytes.push_back(8'($urandom));
         bytes.push_back(dst);
         bytes.push_back(8'(len));
         nd = (len > 40) ? 40 : len;
         repeat (nd) bytes.push_back(8'($urandom));
      end
      sum = '0;
      foreach (bytes[i]) sum += bytes[i];
      bytes.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
      foreach (bytes[i]) if (cut < 0 || i < cut) push_hex(bytes[i]);
      if (cut < 0 && $urandom_range(7) == 0) repeat ($urandom_range(1, 3)) push_hex(8'($urandom));
      if (end_timeout)
         push_word(ahfr_pkg::KIND_TIMEOUT, 8'($urandom), 2'($urandom), 5'($urandom));
      else
         push_char(ahfr_pkg::CH_LF);
      frames++;
   endtask

   task automatic push_random_frame();
      logic [7:0] hwd, typ, dst;
      int len, cut, r;
      hwd = ($urandom_range(9) == 0) ? 8'($urandom) : {6'd0, cfg_own};
      r = $urandom_range(19);
      typ = (r < 14) ? {7'd0, cfg_utype} : (r < 18) ? {7'd0, ~cfg_utype} : 8'($urandom);
      dst = ($urandom_range(11) == 0) ? 8'($urandom) : 8'($urandom_range(ahfr_pkg::NODES - 1));
      r = $urandom_range(29);
      len = (r == 0) ? $urandom_range(ahfr_pkg::MAX_DATA + 1, 255) :
            (r < 4) ? $urandom_range(ahfr_pkg::MAX_DATA) : $urandom_range(6);
      cut = ($urandom_range(9) == 0) ? $urandom_range(12) : -1;
      push_frame(hwd, typ, dst, len, $urandom_range(9) == 0, cut,
                 $urandom_range(11) == 0, cfg_role && $urandom_range(19) == 0);
   endtask

   task automatic push_random_extras();
      int r;
      repeat ($urandom_range(2)) begin
         r = $urandom_range(19);
         if (r < 8)
            push_read();
         else if (r < 12)
            push_word(ahfr_pkg::KIND_RELEASE, 8'($urandom), 2'($urandom), 5'($urandom));
         else if (r < 14)
            push_word(ahfr_pkg::KIND_TIMEOUT, 8'($urandom), 2'($urandom), 5'($urandom));
         else if (r < 16)
            push_word(3'($urandom_range(5, 7)), 8'($urandom), 2'($urandom), 5'($urandom));
         else
            push_word(ahfr_pkg::KIND_CHAR, 8'($urandom), 2'($urandom), 5'($urandom));
      end
   endtask

   task automatic write_csr(logic [1:0] index, logic [1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         ahfr_pkg::CSR_NODE_ROLE: cfg_role  = value[0];
         ahfr_pkg::CSR_OWN_ADDR:  cfg_own   = value;
         ahfr_pkg::CSR_USER_TYPE: cfg_utype = value[0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Word driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) accepted++;
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            event_word_type w;
            w = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, w.idx, w.node, w.ch};
            req_tuser  <= w.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor and watchdog.
   always @(posedge clock) begin
      frame_result_type e, a;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", expected_results.size());
            $display("== FAIL ==");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            a = {rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                 rsp_tdata[31:24], rsp_tdata[39:32], rsp_tdata[47:40]};
            checked++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result word %h.", a);
            end else begin
               e = expected_results.pop_front();
               if (e.st !== a.st || e.hw !== a.hw || e.ty !== a.ty || e.sr !== a.sr ||
                   e.ds !== a.ds || e.ln !== a.ln || e.db !== a.db) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"Result %0d mismatch: expected st=%0d %h_%h_%h_%h_%h_%h, ",
                               "got st=%0d %h_%h_%h_%h_%h_%h"},
                              checked, e.st, e.hw, e.ty, e.sr, e.ds, e.ln, e.db,
                              a.st, a.hw, a.ty, a.sr, a.ds, a.ln, a.db);
               end
            end
         end
      end
   end

   initial begin
      logic [3:0] cfgs [6];
      cfg_role = 1'b0; cfg_own = '0; cfg_utype = 1'b1;
      ph = P_IDLE; hnib = '0; rsum = '0; fcnt = 0; polled = '0;
      foreach (hdr[k]) hdr[k] = '0;
      for (int i = 0; i < ahfr_pkg::NODES; i++) begin
         full_flag[i] = 1'b0;
         meta[i] = '0;
         for (int j = 0; j < ahfr_pkg::MAX_DATA; j++) begin
            store[i][j] = '0;
            written[i][j] = 1'b0;
         end
      end
      master_addr = '0; is_master_l = 1'b0; err = '0; sum_ok = 1'b0; n_items = 0;
      cfgs = '{4'b0001, 4'b1110, 4'b1001, 4'b0110, 4'($urandom), 4'($urandom)};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (seg = 0; seg < 6; seg++) begin
         send_idle_pct = (seg < 2) ? 38 : (seg < 4) ? 70 : 0;
         recv_idle_pct = (seg < 2) ? 70 : (seg < 4) ? 38 : 0;
         write_csr(ahfr_pkg::CSR_NODE_ROLE, {1'b0, cfgs[seg][3]});
         write_csr(ahfr_pkg::CSR_OWN_ADDR,  cfgs[seg][2:1]);
         write_csr(ahfr_pkg::CSR_USER_TYPE, {1'b0, cfgs[seg][0]});
         n_items = 0;
         if (seg == 0) begin
            // Slave: good user frame, poll, type error, bad checksum, too long, short frame.
            push_word(ahfr_pkg::KIND_TIMEOUT, 8'hFF, 2'd3, 5'd31);
            push_frame(8'h00, 8'h01, 8'h00, ahfr_pkg::MAX_DATA, 1'b0, -1, 1'b0, 1'b0);
            if (written[0][31]) push_word(ahfr_pkg::KIND_READ, 8'h00, 2'd0, 5'd31);
            if (written[0][0]) push_word(ahfr_pkg::KIND_READ, 8'hFF, 2'd0, 5'd0);
            push_frame(8'h00, 8'h00, 8'h00, 0, 1'b0, -1, 1'b0, 1'b0);
            push_frame(8'h00, 8'hFF, 8'h00, 0, 1'b0, -1, 1'b0, 1'b0);
            push_frame(8'h00, 8'h01, 8'h00, 2, 1'b1, -1, 1'b0, 1'b0);
            push_frame(8'h00, 8'h01, 8'h00, ahfr_pkg::MAX_DATA + 1, 1'b0, -1, 1'b0, 1'b0);
            push_frame(8'h00, 8'h01, 8'h00, 3, 1'b0, 4, 1'b0, 1'b0);
            push_frame(8'h00, 8'h01, 8'h00, 3, 1'b0, 1, 1'b0, 1'b0);
            push_word(ahfr_pkg::KIND_START, 8'h00, 2'd0, 5'd0);
            push_word(ahfr_pkg::KIND_TIMEOUT, 8'h00, 2'd0, 5'd0);
            push_word(ahfr_pkg::KIND_RELEASE, 8'h00, 2'd0, 5'd0);
            push_word(3'd7, 8'h55, 2'd2, 5'd21);
         end else if (seg == 1) begin
            // Master: full destination, destination out of range, wrong address, bad first char.
            push_frame(8'h03, 8'h00, 8'h01, 1, 1'b0, -1, 1'b0, 1'b0);
            push_frame(8'h03, 8'h00, 8'h01, 1, 1'b0, -1, 1'b0, 1'b0);
            push_frame(8'h03, 8'h00, 8'h04, 1, 1'b0, -1, 1'b0, 1'b0);
            push_frame(8'h02, 8'h00, 8'h00, 1, 1'b0, 3, 1'b1, 1'b0);
            push_frame(8'h03, 8'h00, 8'h00, 1, 1'b0, 3, 1'b1, 1'b1);
            push_frame(8'h03, 8'h00, 8'h00, 1, 1'b0, 2, 1'b1, 1'b0);
            push_word(ahfr_pkg::KIND_START, 8'h00, 2'd1, 5'd0);
            push_word(ahfr_pkg::KIND_TIMEOUT, 8'h00, 2'd0, 5'd0);
         end
         while (n_items < 285) begin
            push_random_frame();
            push_random_extras();
         end
         wait_drained();
      end
      $display("Sent %0d words in %0d frames over six register settings; checked %0d results.",
               accepted, frames, checked);
      $display("Mismatches: %0d, results never seen: %0d.", mismatches, expected_results.size());
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ ascii_hex_frame_receiver_core.f @@
rtl/ahfr_pkg.sv
rtl/ahfr_front.sv
rtl/ahfr_queue.sv
rtl/ahfr_back.sv
rtl/ascii_hex_frame_receiver_core.sv
tb/ascii_hex_frame_receiver_core_tb.sv
